// ===== sv/key_value_token_classifier_core_defines.svh =====
`ifndef KEY_VALUE_TOKEN_CLASSIFIER_CORE_DEFINES_SVH
`define KEY_VALUE_TOKEN_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTH
`define KVTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kvtc assertion failed");
`define KVTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kvtc assertion failed");
`else
`define KVTC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KVTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/kvtc_pkg.sv =====
package kvtc_pkg;

	localparam int KEY_W   = 8;
	localparam int VALUE_W = 12;
	localparam int CFG_INDEX_W = 1;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LIMIT   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LIMIT = 1'd1;

	localparam logic [KEY_W-1:0]   KEY_LIMIT_RESET   = 8'd64;
	localparam logic [VALUE_W-1:0] VALUE_LIMIT_RESET = 12'd1024;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_DASH       = 8'h2D;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_EQUALS     = 8'h3D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_TILDE      = 8'h7E;
	localparam logic [7:0] CH_FILL       = 8'hFF;

	typedef enum logic [2:0] {
		ROLE_KEY,
		ROLE_EQUALS,
		ROLE_VALUE,
		ROLE_COLON,
		ROLE_SIG,
		ROLE_SIG_DROP
	} kvtc_role_t;

	typedef enum logic [2:0] {
		VERDICT_NONE,
		VERDICT_SIG,
		VERDICT_PAIR,
		VERDICT_TOO_LONG,
		VERDICT_BAD_KEY
	} kvtc_verdict_t;

	typedef struct packed {
		logic               in_token;
		logic               is_signature;
		logic               seen_equals;
		logic               key_bad;
		logic [KEY_W-1:0]   key_count;
		logic [VALUE_W-1:0] value_count;
	} kvtc_token_t;

	typedef struct packed {
		logic               is_verdict;
		logic [7:0]         out_byte;
		kvtc_role_t         role;
		kvtc_verdict_t      verdict;
		logic [KEY_W-1:0]   key_length;
		logic [VALUE_W-1:0] value_length;
		logic               buffer_end;
		logic               run_last;
	} kvtc_result_t;

	localparam kvtc_token_t TOKEN_CLEAR = '{
		in_token: 1'b0, is_signature: 1'b0, seen_equals: 1'b0, key_bad: 1'b0,
		key_count: '0, value_count: '0
	};

endpackage

// ===== sv/kvtc_ifs.sv =====
interface kvtc_cfg_if import kvtc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [VALUE_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface kvtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_last;

	modport source (output valid, data_byte, buffer_last, input ready);
	modport sink (input valid, data_byte, buffer_last, output ready);
endinterface

interface kvtc_out_if import kvtc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               is_verdict;
	logic [7:0]         out_byte;
	logic [2:0]         role;
	logic [2:0]         verdict;
	logic [KEY_W-1:0]   key_length;
	logic [VALUE_W-1:0] value_length;
	logic               buffer_end;
	logic               run_last;

	modport source (output valid, is_verdict, out_byte, role, verdict, key_length,
		value_length, buffer_end, run_last, input ready);
	modport sink (input valid, is_verdict, out_byte, role, verdict, key_length,
		value_length, buffer_end, run_last, output ready);
endinterface

// ===== sv/kvtc_step.sv =====
module kvtc_step import kvtc_pkg::*; (
	input  kvtc_token_t        tok,
	input  logic [7:0]         data_byte,
	input  logic               buffer_last,
	input  logic [KEY_W-1:0]   key_limit,
	input  logic [VALUE_W-1:0] value_limit,
	output kvtc_token_t        tok_next,
	output kvtc_result_t       res0,
	output kvtc_result_t       res1,
	output logic [1:0]         n_results
);

	logic [KEY_W-1:0]   eff_key;
	logic [VALUE_W-1:0] eff_value;
	logic               is_term;
	logic               is_skip;
	logic               key_ok;
	kvtc_token_t        tok_c;
	kvtc_role_t         role_c;
	kvtc_result_t       content_res;

	function automatic kvtc_result_t make_verdict(kvtc_token_t t, logic bend,
			logic [KEY_W-1:0] ekl, logic [VALUE_W-1:0] evl);
		kvtc_result_t r;
		r = '0;
		r.is_verdict   = 1'b1;
		r.key_length   = t.key_count;
		r.value_length = t.value_count;
		r.buffer_end   = bend;
		r.run_last     = 1'b1;
		if (t.is_signature) begin
			r.verdict    = (t.value_count != '0) ? VERDICT_SIG : VERDICT_NONE;
			r.key_length = '0;
		end else if (!t.seen_equals || t.key_count == '0) begin
			r.verdict = VERDICT_NONE;
		end else if (t.key_count >= ekl || t.value_count >= evl) begin
			r.verdict = VERDICT_TOO_LONG;
		end else if (t.key_bad) begin
			r.verdict = VERDICT_BAD_KEY;
		end else begin
			r.verdict = VERDICT_PAIR;
		end
		return r;
	endfunction

	assign eff_key   = (key_limit == '0) ? KEY_W'(1) : key_limit;
	assign eff_value = (value_limit == '0) ? VALUE_W'(1) : value_limit;

	assign is_term = (data_byte == CH_TILDE) || (data_byte == CH_COMMA) ||
		(data_byte == CH_CR) || (data_byte == CH_LF) ||
		(data_byte == CH_NUL) || (data_byte == CH_FILL);
	assign is_skip = is_term || (data_byte <= CH_SPACE);

	assign key_ok = (data_byte >= 8'h61 && data_byte <= 8'h7A) ||
		(data_byte >= 8'h41 && data_byte <= 8'h5A) ||
		(data_byte >= 8'h30 && data_byte <= 8'h39) ||
		(data_byte == CH_UNDERSCORE) || (data_byte == CH_DASH) ||
		(data_byte == CH_DOT);

	always_comb begin
		tok_c  = tok;
		role_c = ROLE_KEY;
		if (!tok.in_token && data_byte == CH_COLON) begin
			tok_c.in_token     = 1'b1;
			tok_c.is_signature = 1'b1;
			role_c             = ROLE_COLON;
		end else begin
			tok_c.in_token = 1'b1;
			if (tok.is_signature) begin
				role_c = (({1'b0, tok.value_count} + 13'd1) < {1'b0, eff_value}) ?
					ROLE_SIG : ROLE_SIG_DROP;
				if (tok.value_count < eff_value)
					tok_c.value_count = tok.value_count + VALUE_W'(1);
			end else if (!tok.seen_equals) begin
				if (data_byte == CH_EQUALS) begin
					tok_c.seen_equals = 1'b1;
					role_c            = ROLE_EQUALS;
				end else begin
					role_c = ROLE_KEY;
					if (!key_ok)
						tok_c.key_bad = 1'b1;
					if (tok.key_count < eff_key)
						tok_c.key_count = tok.key_count + KEY_W'(1);
				end
			end else begin
				role_c = ROLE_VALUE;
				if (tok.value_count < eff_value)
					tok_c.value_count = tok.value_count + VALUE_W'(1);
			end
		end
	end

	always_comb begin
		content_res            = '0;
		content_res.out_byte   = data_byte;
		content_res.role       = role_c;
		content_res.run_last   = !buffer_last;
	end

	always_comb begin
		res0      = content_res;
		res1      = make_verdict(tok_c, 1'b1, eff_key, eff_value);
		tok_next  = tok;
		n_results = 2'd0;
		if (tok.in_token && is_term) begin
			res0      = make_verdict(tok, buffer_last, eff_key, eff_value);
			tok_next  = TOKEN_CLEAR;
			n_results = 2'd1;
		end else if (!tok.in_token && is_skip) begin
			n_results = 2'd0;
		end else begin
			tok_next  = buffer_last ? TOKEN_CLEAR : tok_c;
			n_results = buffer_last ? 2'd2 : 2'd1;
		end
	end

endmodule

// ===== sv/key_value_token_classifier_core.sv =====
// Key/value token classifier.
// byte_stream: one raw configuration byte per request, with buffer_last on
//   the final byte of the block. results: classified bytes and token verdicts.
// cfg: register writes, index 0 key_limit, index 1 value_limit; always ready.
//   Write only while no results are pending.
// Each accepted byte is classified in the cycle it is accepted and yields
//   zero, one or two results, written into a four-entry result queue.
// The results of an accepted byte are registered in the queue. A byte is
//   taken every cycle while the queue holds two or fewer results, so
//   one-result bytes run at one byte per cycle while the receiver keeps
//   taking results; a two-result byte (content on the final byte) adds two.
// When the receiver stalls, results hold in the queue and byte_stream.ready
//   drops once three or more are pending.
// Reset clears the token state and the queue and loads key_limit 64 and
//   value_limit 1024.
`include "key_value_token_classifier_core_defines.svh"

module key_value_token_classifier_core import kvtc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	kvtc_cfg_if.sink   cfg,
	kvtc_in_if.sink    byte_stream,
	kvtc_out_if.source results
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [KEY_W-1:0]   key_limit_q;
	logic [VALUE_W-1:0] value_limit_q;
	kvtc_token_t        tok_q;
	kvtc_token_t        tok_next;
	kvtc_result_t       res0;
	kvtc_result_t       res1;
	logic [1:0]         n_results;
	kvtc_result_t       queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;
	kvtc_result_t       head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q   <= KEY_LIMIT_RESET;
			value_limit_q <= VALUE_LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KEY_LIMIT:   key_limit_q   <= cfg.data[KEY_W-1:0];
				REG_VALUE_LIMIT: value_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	kvtc_step u_step (
		.tok         (tok_q),
		.data_byte   (byte_stream.data_byte),
		.buffer_last (byte_stream.buffer_last),
		.key_limit   (key_limit_q),
		.value_limit (value_limit_q),
		.tok_next    (tok_next),
		.res0        (res0),
		.res1        (res1),
		.n_results   (n_results)
	);

	assign byte_stream.ready = (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign push = byte_stream.valid && byte_stream.ready;
	assign pop  = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= TOKEN_CLEAR;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				tok_q    <= tok_next;
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_results);
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + (push ? CNT_W'(n_results) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && n_results != 2'd0)
			queue_q[wr_ptr_q] <= res0;
		if (push && n_results == 2'd2)
			queue_q[wr_ptr_q + PTR_W'(1)] <= res1;
	end

	assign head                 = queue_q[rd_ptr_q];
	assign results.valid        = (cnt_q != '0);
	assign results.is_verdict   = head.is_verdict;
	assign results.out_byte     = head.out_byte;
	assign results.role         = head.role;
	assign results.verdict      = head.verdict;
	assign results.key_length   = head.key_length;
	assign results.value_length = head.value_length;
	assign results.buffer_end   = head.buffer_end;
	assign results.run_last     = head.run_last;

	`KVTC_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH))
	`KVTC_ASSERT_NOW(a_pair_order, clk, arst_n, push && n_results == 2'd2,
		!res0.is_verdict && res1.is_verdict && byte_stream.buffer_last)
	`KVTC_ASSERT_NEXT(a_verdict_clears, clk, arst_n,
		push && n_results != 2'd0 && res0.is_verdict, !tok_q.in_token)

endmodule
